// ----- rtl/tplme_pkg.sv -----
// ----------------------------------------------------------------------------
// tplme_pkg: shared types and codes for the tree path query block
// Request and result payloads, configuration indexes and shared-unit codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tplme_pkg;

  localparam int NODE_W = 10;
  localparam int LEN_W  = 16;
  localparam int DIST_W = 26;

  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [LEN_W-1:0]  edge_length;
    logic              last_edge;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] path_result;
    logic              unreachable;
    logic              store_full;
  } res_t;

  // configuration register indexes
  localparam logic CFG_START_NODE = 1'b0;
  localparam logic CFG_END_NODE   = 1'b1;

  // shared arithmetic unit operations
  typedef enum logic [1:0] {
    OP_ADD_SAT = 2'd0,
    OP_MAX     = 2'd1,
    OP_SUB_CLAMP = 2'd2
  } alu_op_t;

endpackage

`default_nettype wire

// ----- rtl/tplme_alu.sv -----
// ----------------------------------------------------------------------------
// tplme_alu: shared arithmetic unit
// Saturating add, maximum, and subtract clamped at zero on distance words.
// ----------------------------------------------------------------------------
`default_nettype none

module tplme_alu (
  input  tplme_pkg::alu_op_t               op,
  input  logic [tplme_pkg::DIST_W-1:0]     a,
  input  logic [tplme_pkg::DIST_W-1:0]     b,
  output logic [tplme_pkg::DIST_W-1:0]     y
);

  logic [tplme_pkg::DIST_W:0] sum;

  // form the wide sum once for the saturating add
  assign sum = {1'b0, a} + {1'b0, b};

  // select the operation
  always_comb begin
    case (op)
      tplme_pkg::OP_ADD_SAT: begin
        y = sum[tplme_pkg::DIST_W] ? {tplme_pkg::DIST_W{1'b1}}
                                   : sum[tplme_pkg::DIST_W-1:0];
      end
      tplme_pkg::OP_MAX: begin
        y = (a > b) ? a : b;
      end
      tplme_pkg::OP_SUB_CLAMP: begin
        y = (a >= b) ? (a - b) : '0;
      end
      default: begin
        y = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tree_path_length_minus_max_edge_top.sv -----
// ----------------------------------------------------------------------------
// tree_path_length_minus_max_edge_top: weighted tree path query
// Loads tree edges into linked adjacency lists, walks breadth first from the
// start node, traces parents back from the end node and reports the path
// length minus the longest edge on that path.
// ----------------------------------------------------------------------------
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------------
//  request  | start, busy, req                 | taken when start & !busy
//  result   | done, result                     | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, | taken when cfg_valid &
//           | cfg_data                         | cfg_ready (always ready)
//
//  An edge request: the accept cycle reads the first head, then S_WR_A and
//  S_WR_B each link one direction through the single head memory port.
//  The request marked last then runs the walk: per node popped S_POP, S_POP_W,
//  S_HEAD_W; per list entry scanned S_EDGE_W, S_VIS_W; per traced path edge
//  S_BT, S_BT_W; set by the one-read-port memories and shared arithmetic unit.
//  After each result, and after reset, a clearing pass over min(MAX_NODES,1024)
//  entries empties the heads and visited map; busy stays high throughout.
//  The receiver cannot stall: done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_path_length_minus_max_edge_top #(
  parameter int MAX_NODES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  tplme_pkg::req_t                  req,
  output logic                             done,
  output tplme_pkg::res_t                  result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [tplme_pkg::NODE_W-1:0]     cfg_data
);

  localparam int NODES    = (MAX_NODES < 1024) ? MAX_NODES : 1024;
  localparam int NAW      = $clog2(NODES);
  localparam int EDGE_CAP = 2 * MAX_NODES;
  localparam int EW       = $clog2(EDGE_CAP);
  localparam int NW       = tplme_pkg::NODE_W;
  localparam int LW       = tplme_pkg::LEN_W;
  localparam int DW       = tplme_pkg::DIST_W;

  typedef enum logic [14:0] {
    S_CLEAR  = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_WR_A   = 15'b000000000000100,
    S_WR_B   = 15'b000000000001000,
    S_Q_INIT = 15'b000000000010000,
    S_POP    = 15'b000000000100000,
    S_POP_W  = 15'b000000001000000,
    S_HEAD_W = 15'b000000010000000,
    S_EDGE_W = 15'b000000100000000,
    S_VIS_W  = 15'b000001000000000,
    S_VE_RD  = 15'b000010000000000,
    S_VE_W   = 15'b000100000000000,
    S_BT     = 15'b001000000000000,
    S_BT_W   = 15'b010000000000000,
    S_FINAL  = 15'b100000000000000
  } state_t;

  function automatic logic in_range(input logic [NW-1:0] n);
    in_range = 32'(n) < MAX_NODES;
  endfunction

  // memories
  logic          head_ok_mem  [NODES];
  logic [EW-1:0] head_idx_mem [NODES];
  logic          edge_ok_mem  [EDGE_CAP];
  logic [EW-1:0] edge_link_mem[EDGE_CAP];
  logic [NAW-1:0] edge_node_mem[EDGE_CAP];
  logic [LW-1:0] edge_len_mem [EDGE_CAP];
  logic          vis_mem      [NODES];
  logic [DW-1:0] dist_mem     [NODES];
  logic [NAW-1:0] par_node_mem[NODES];
  logic [LW-1:0] par_len_mem  [NODES];
  logic [NAW-1:0] queue_mem   [NODES];

  // registers
  state_t         state;
  logic [NAW-1:0] clr;
  logic [NW-1:0]  start_node;
  logic [NW-1:0]  end_node;
  logic [EW:0]    edge_count;
  logic           dropped;
  logic [NW-1:0]  node_a;
  logic [NW-1:0]  node_b;
  logic [LW-1:0]  edge_len;
  logic           last_edge;
  logic [NAW:0]   qhead;
  logic [NAW:0]   qtail;
  logic [NAW-1:0] cur_u;
  logic [DW-1:0]  cur_dist;
  logic [NAW-1:0] cur_v;
  logic [LW-1:0]  cur_len;
  logic           cur_link_ok;
  logic [EW-1:0]  cur_link;
  logic [DW-1:0]  end_dist;
  logic [DW-1:0]  longest;
  logic [NAW-1:0] trace;
  logic           miss;

  // read data registers
  logic           head_ok_rd;
  logic [EW-1:0]  head_idx_rd;
  logic           edge_ok_rd;
  logic [EW-1:0]  edge_link_rd;
  logic [NAW-1:0] edge_node_rd;
  logic [LW-1:0]  edge_len_rd;
  logic           vis_rd;
  logic [DW-1:0]  dist_rd;
  logic [NAW-1:0] par_node_rd;
  logic [LW-1:0]  par_len_rd;
  logic [NAW-1:0] queue_rd;

  // read addresses
  logic [NAW-1:0] head_ra;
  logic [EW-1:0]  edge_ra;
  logic [NAW-1:0] vis_ra;
  logic [NAW-1:0] dist_ra;

  // shared unit
  tplme_pkg::alu_op_t alu_op;
  logic [DW-1:0]      alu_a;
  logic [DW-1:0]      alu_b;
  logic [DW-1:0]      alu_y;

  logic          edge_ok;
  logic          edge_fits;
  logic [EW-1:0] slot_a;
  logic [EW-1:0] slot_b;
  logic          head_b_ok;
  logic [EW-1:0] head_b_idx;

  tplme_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign edge_ok   = in_range(node_a) && in_range(node_b);
  assign edge_fits = ((EW+2)'(edge_count) + (EW+2)'(2)) <= (EW+2)'(EDGE_CAP);
  assign slot_a    = edge_count[EW-1:0];
  assign slot_b    = edge_count[EW-1:0] + EW'(1);

  // forward the first link when both ends are the same node
  assign head_b_ok  = (node_a == node_b) ? 1'b1   : head_ok_rd;
  assign head_b_idx = (node_a == node_b) ? slot_a : head_idx_rd;

  // pick the operation for the shared unit
  always_comb begin
    case (state)
      S_VIS_W: begin
        alu_op = tplme_pkg::OP_ADD_SAT;
        alu_a  = cur_dist;
        alu_b  = DW'(cur_len);
      end
      S_BT_W: begin
        alu_op = tplme_pkg::OP_MAX;
        alu_a  = longest;
        alu_b  = DW'(par_len_rd);
      end
      default: begin
        alu_op = tplme_pkg::OP_SUB_CLAMP;
        alu_a  = end_dist;
        alu_b  = longest;
      end
    endcase
  end

  // select read addresses
  always_comb begin
    head_ra = cur_u;
    edge_ra = cur_link;
    vis_ra  = end_node[NAW-1:0];
    dist_ra = end_node[NAW-1:0];
    case (state)
      S_IDLE:   head_ra = req.node_a[NAW-1:0];
      S_WR_A:   head_ra = node_b[NAW-1:0];
      S_POP_W: begin
        head_ra = queue_rd;
        dist_ra = queue_rd;
      end
      S_HEAD_W: edge_ra = head_idx_rd;
      S_EDGE_W: vis_ra  = edge_node_rd;
      default: begin
      end
    endcase
  end

  // head memory
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      head_ok_mem[clr] <= 1'b0;
    end else if (state == S_WR_A && edge_ok && edge_fits) begin
      head_ok_mem[node_a[NAW-1:0]]  <= 1'b1;
      head_idx_mem[node_a[NAW-1:0]] <= slot_a;
    end else if (state == S_WR_B) begin
      head_ok_mem[node_b[NAW-1:0]]  <= 1'b1;
      head_idx_mem[node_b[NAW-1:0]] <= slot_b;
    end
    head_ok_rd  <= head_ok_mem[head_ra];
    head_idx_rd <= head_idx_mem[head_ra];
  end

  // edge memory
  always_ff @(posedge clk) begin
    if (state == S_WR_A && edge_ok && edge_fits) begin
      edge_ok_mem[slot_a]   <= head_ok_rd;
      edge_link_mem[slot_a] <= head_idx_rd;
      edge_node_mem[slot_a] <= node_b[NAW-1:0];
      edge_len_mem[slot_a]  <= edge_len;
    end else if (state == S_WR_B) begin
      edge_ok_mem[slot_b]   <= head_b_ok;
      edge_link_mem[slot_b] <= head_b_idx;
      edge_node_mem[slot_b] <= node_a[NAW-1:0];
      edge_len_mem[slot_b]  <= edge_len;
    end
    edge_ok_rd   <= edge_ok_mem[edge_ra];
    edge_link_rd <= edge_link_mem[edge_ra];
    edge_node_rd <= edge_node_mem[edge_ra];
    edge_len_rd  <= edge_len_mem[edge_ra];
  end

  // visited map
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      vis_mem[clr] <= 1'b0;
    end else if (state == S_Q_INIT) begin
      vis_mem[start_node[NAW-1:0]] <= 1'b1;
    end else if (state == S_VIS_W && !vis_rd) begin
      vis_mem[cur_v] <= 1'b1;
    end
    vis_rd <= vis_mem[vis_ra];
  end

  // distance, parent and queue memories
  always_ff @(posedge clk) begin
    if (state == S_Q_INIT) begin
      dist_mem[start_node[NAW-1:0]] <= '0;
      queue_mem[NAW'(0)]            <= start_node[NAW-1:0];
    end else if (state == S_VIS_W && !vis_rd) begin
      dist_mem[cur_v]             <= alu_y;
      par_node_mem[cur_v]         <= cur_u;
      par_len_mem[cur_v]          <= cur_len;
      queue_mem[qtail[NAW-1:0]]   <= cur_v;
    end
    dist_rd     <= dist_mem[dist_ra];
    par_node_rd <= par_node_mem[trace];
    par_len_rd  <= par_len_mem[trace];
    queue_rd    <= queue_mem[qhead[NAW-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_node <= '0;
      end_node   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tplme_pkg::CFG_START_NODE: start_node <= cfg_data;
        tplme_pkg::CFG_END_NODE:   end_node   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // hold request payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      node_a    <= req.node_a;
      node_b    <= req.node_b;
      edge_len  <= req.edge_length;
      last_edge <= req.last_edge;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      edge_count <= '0;
      dropped    <= 1'b0;
      qhead      <= '0;
      qtail      <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + NAW'(1);
          if (clr == NAW'(NODES - 1)) begin
            clr   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_WR_A;
          end
        end
        S_WR_A: begin
          if (edge_ok && edge_fits) begin
            state <= S_WR_B;
          end else begin
            if (edge_ok) begin
              dropped <= 1'b1;
            end
            state <= last_edge ? S_Q_INIT : S_IDLE;
          end
        end
        S_WR_B: begin
          edge_count <= edge_count + (EW+1)'(2);
          state      <= last_edge ? S_Q_INIT : S_IDLE;
        end
        S_Q_INIT: begin
          end_dist <= '0;
          longest  <= '0;
          miss     <= 1'b0;
          qhead    <= '0;
          qtail    <= (NAW+1)'(1);
          if (!in_range(start_node) || !in_range(end_node)) begin
            miss  <= 1'b1;
            state <= S_FINAL;
          end else if (start_node == end_node) begin
            state <= S_FINAL;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          if (qhead == qtail) begin
            state <= S_VE_RD;
          end else begin
            qhead <= qhead + (NAW+1)'(1);
            state <= S_POP_W;
          end
        end
        S_POP_W: begin
          cur_u <= queue_rd;
          state <= S_HEAD_W;
        end
        S_HEAD_W: begin
          cur_dist <= dist_rd;
          state    <= head_ok_rd ? S_EDGE_W : S_POP;
        end
        S_EDGE_W: begin
          cur_v       <= edge_node_rd;
          cur_len     <= edge_len_rd;
          cur_link_ok <= edge_ok_rd;
          cur_link    <= edge_link_rd;
          state       <= S_VIS_W;
        end
        S_VIS_W: begin
          if (!vis_rd) begin
            qtail <= qtail + (NAW+1)'(1);
          end
          state <= cur_link_ok ? S_EDGE_W : S_POP;
        end
        S_VE_RD: begin
          state <= S_VE_W;
        end
        S_VE_W: begin
          trace <= end_node[NAW-1:0];
          if (!vis_rd) begin
            miss  <= 1'b1;
            state <= S_FINAL;
          end else begin
            end_dist <= dist_rd;
            state    <= S_BT;
          end
        end
        S_BT: begin
          state <= (trace == start_node[NAW-1:0]) ? S_FINAL : S_BT_W;
        end
        S_BT_W: begin
          longest <= alu_y;
          trace   <= par_node_rd;
          state   <= S_BT;
        end
        S_FINAL: begin
          done               <= 1'b1;
          result.path_result <= miss ? '0 : alu_y;
          result.unreachable <= miss;
          result.store_full  <= dropped;
          edge_count         <= '0;
          dropped            <= 1'b0;
          clr                <= '0;
          state              <= S_CLEAR;
        end
        default: begin
          state <= S_CLEAR;
          clr   <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
